// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the node pool queue manager RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, quiet while reset is asserted.
`define NPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define NPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/npqm_pkg.sv =====
// Shared types for the node pool queue manager: operation codes and sequencer states.
// No dependencies.
package npqm_pkg;

	typedef enum logic [2:0] {
		OP_ALLOC     = 3'd0,
		OP_FREE      = 3'd1,
		OP_INSERT    = 3'd2,
		OP_RM_HEAD   = 3'd3,
		OP_RM_NODE   = 3'd4,
		OP_PEEK_HEAD = 3'd5
	} op_t;

	localparam int StateW = 14;

	typedef enum logic [StateW-1:0] {
		S_IDLE = 14'b00000000000001,
		S_DISP = 14'b00000000000010,
		S_ALC  = 14'b00000000000100,
		S_INS1 = 14'b00000000001000,
		S_INS2 = 14'b00000000010000,
		S_RH1  = 14'b00000000100000,
		S_RH2  = 14'b00000001000000,
		S_RH3  = 14'b00000010000000,
		S_PEEK = 14'b00000100000000,
		S_CMP  = 14'b00001000000000,
		S_WALK = 14'b00010000000000,
		S_F2   = 14'b00100000000000,
		S_F3   = 14'b01000000000000,
		S_DONE = 14'b10000000000000
	} state_t;

endpackage

// ===== hdl/node_pool_queue_manager_unit.sv =====
// Node pool queue manager: free stack plus circular doubly linked queues over one node pool.
// Depends on npqm_pkg and assert_macros.svh.
//
// Each transaction carries one operation and returns one result. A small sequencer drives
// one read and one write port on each link memory (next and prev), so an operation lasts as
// long as its chain of dependent link reads and writes. Free, and any operation that ends
// early on a none index, an empty queue or an empty pool, is the shortest; remove of a given
// node walks the ring one node at a time, each through a compare state and a walk state. A
// stalled result adds its stall on top. A new transaction is accepted once the sequencer is
// back in idle, while the previous result may still wait in the output register. No clearing
// pass follows reset: next links start from per-entry valid bits, prev links are undefined
// until written.
`include "assert_macros.svh"

module node_pool_queue_manager_unit #(
	parameter int NODES = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// operation, node, tail (lowest bit first), zero padded
	input  logic [((3+2*$clog2(NODES+1)+7)/8)*8-1:0] s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// result_node, new_tail (lowest bit first), zero padded
	output logic [((2*$clog2(NODES+1)+7)/8)*8-1:0]   m_tdata
);

	localparam int LW    = $clog2(NODES + 1);
	localparam int IW    = $clog2(NODES);
	localparam int OUT_W = ((2 * LW + 7) / 8) * 8;
	localparam logic [LW-1:0] NONE = LW'(NODES);
	localparam logic [IW-1:0] LAST = IW'(NODES - 1);

	npqm_pkg::state_t state_q;
	logic [2:0]    op_q;
	logic [LW-1:0] node_q, tail_q, res_q, h_q, cur_q, fh_q;
	logic [IW-1:0] k_q;

	logic [LW-1:0] next_mem [NODES];
	logic [LW-1:0] prev_mem [NODES];
	logic [NODES-1:0] nv_q;
	logic [LW-1:0] n_rd_q, p_rd_q;
	logic [IW-1:0] n_ra_q;
	logic          n_v_q;

	logic [IW-1:0] n_ra, p_ra, n_wa, p_wa;
	logic [LW-1:0] n_wd, p_wd, n_val, p_val;
	logic          n_we, p_we;

	logic [LW-1:0] in_node, in_tail, in_node_n, in_tail_n;
	logic [2:0]    in_op;
	logic [OUT_W-1:0] out_q;
	logic          out_v_q;

	assign in_op     = s_tdata[2:0];
	assign in_node   = s_tdata[LW+2:3];
	assign in_tail   = s_tdata[2*LW+2:LW+3];
	assign in_node_n = (in_node < NONE) ? in_node : NONE;
	assign in_tail_n = (in_tail < NONE) ? in_tail : NONE;

	assign s_tready = (state_q == npqm_pkg::S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	// Unwritten next entries read as their reset link i+1.
	assign n_val = n_v_q ? n_rd_q : (LW'(n_ra_q) + LW'(1));
	assign p_val = p_rd_q;

	always_comb begin
		n_ra = cur_q[IW-1:0];
		p_ra = cur_q[IW-1:0];
		case (state_q)
			npqm_pkg::S_DISP: begin
				n_ra = fh_q[IW-1:0];
				p_ra = tail_q[IW-1:0];
			end
			npqm_pkg::S_RH1: p_ra = p_val[IW-1:0];
			default: ;
		endcase
	end

	always_comb begin
		n_we = 1'b0;
		n_wa = node_q[IW-1:0];
		n_wd = NONE;
		p_we = 1'b0;
		p_wa = node_q[IW-1:0];
		p_wd = NONE;
		case (state_q)
			npqm_pkg::S_DISP: begin
				if (op_q == npqm_pkg::OP_FREE && node_q < NONE) begin
					n_we = 1'b1;
					n_wd = fh_q;
				end else if (op_q == npqm_pkg::OP_INSERT && node_q < NONE &&
						tail_q == NONE) begin
					n_we = 1'b1;
					n_wd = node_q;
					p_we = 1'b1;
					p_wd = node_q;
				end
			end
			npqm_pkg::S_ALC: begin
				n_we = 1'b1;
				n_wa = fh_q[IW-1:0];
				p_we = 1'b1;
				p_wa = fh_q[IW-1:0];
			end
			npqm_pkg::S_INS1: begin
				n_we = 1'b1;
				n_wd = tail_q;
				p_we = 1'b1;
				p_wd = p_val;
			end
			npqm_pkg::S_INS2: begin
				n_we = (h_q < NONE);
				n_wa = h_q[IW-1:0];
				n_wd = node_q;
				p_we = 1'b1;
				p_wa = tail_q[IW-1:0];
				p_wd = node_q;
			end
			npqm_pkg::S_RH2: begin
				if (p_val != h_q) begin
					n_we = (p_val < NONE);
					n_wa = p_val[IW-1:0];
					n_wd = tail_q;
					p_we = 1'b1;
					p_wa = tail_q[IW-1:0];
					p_wd = p_val;
				end
			end
			npqm_pkg::S_RH3: begin
				n_we = 1'b1;
				n_wa = h_q[IW-1:0];
				p_we = 1'b1;
				p_wa = h_q[IW-1:0];
			end
			npqm_pkg::S_F2: begin
				// splice the found node out: next of its predecessor, prev of its successor
				if (n_val != cur_q) begin
					n_we = (p_val < NONE);
					n_wa = p_val[IW-1:0];
					n_wd = n_val;
					p_we = (n_val < NONE);
					p_wa = n_val[IW-1:0];
					p_wd = p_val;
				end
			end
			npqm_pkg::S_F3: begin
				n_we = 1'b1;
				n_wa = cur_q[IW-1:0];
				p_we = 1'b1;
				p_wa = cur_q[IW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (n_we)
			next_mem[n_wa] <= n_wd;
		if (p_we)
			prev_mem[p_wa] <= p_wd;
		n_rd_q <= next_mem[n_ra];
		p_rd_q <= prev_mem[p_ra];
		n_ra_q <= n_ra;
		n_v_q  <= nv_q[n_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= '0;
		end else if (n_we) begin
			nv_q[n_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npqm_pkg::S_IDLE;
			fh_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == npqm_pkg::S_DONE && (!out_v_q || m_tready))
				out_v_q <= 1'b1;
			else if (out_v_q && m_tready)
				out_v_q <= 1'b0;
			case (state_q)
				npqm_pkg::S_IDLE: begin
					if (s_tvalid) begin
						op_q    <= in_op;
						node_q  <= in_node_n;
						tail_q  <= in_tail_n;
						res_q   <= NONE;
						state_q <= npqm_pkg::S_DISP;
					end
				end
				npqm_pkg::S_DISP: begin
					case (op_q)
						npqm_pkg::OP_ALLOC:
							state_q <= (fh_q < NONE) ? npqm_pkg::S_ALC : npqm_pkg::S_DONE;
						npqm_pkg::OP_FREE: begin
							if (node_q < NONE)
								fh_q <= node_q;
							state_q <= npqm_pkg::S_DONE;
						end
						npqm_pkg::OP_INSERT: begin
							if (node_q < NONE && tail_q != NONE) begin
								state_q <= npqm_pkg::S_INS1;
							end else begin
								if (node_q < NONE) begin
									tail_q <= node_q;
									res_q  <= node_q;
								end
								state_q <= npqm_pkg::S_DONE;
							end
						end
						npqm_pkg::OP_RM_HEAD:
							state_q <= (tail_q < NONE) ? npqm_pkg::S_RH1 : npqm_pkg::S_DONE;
						npqm_pkg::OP_RM_NODE: begin
							if (tail_q < NONE && node_q < NONE) begin
								cur_q   <= tail_q;
								k_q     <= '0;
								state_q <= npqm_pkg::S_CMP;
							end else begin
								state_q <= npqm_pkg::S_DONE;
							end
						end
						npqm_pkg::OP_PEEK_HEAD:
							state_q <= (tail_q < NONE) ? npqm_pkg::S_PEEK : npqm_pkg::S_DONE;
						default: state_q <= npqm_pkg::S_DONE;
					endcase
				end
				npqm_pkg::S_ALC: begin
					fh_q    <= n_val;
					res_q   <= fh_q;
					state_q <= npqm_pkg::S_DONE;
				end
				npqm_pkg::S_INS1: begin
					h_q     <= p_val;
					state_q <= npqm_pkg::S_INS2;
				end
				npqm_pkg::S_INS2: begin
					tail_q  <= node_q;
					res_q   <= node_q;
					state_q <= npqm_pkg::S_DONE;
				end
				npqm_pkg::S_RH1: begin
					h_q     <= p_val;
					state_q <= (p_val < NONE) ? npqm_pkg::S_RH2 : npqm_pkg::S_DONE;
				end
				npqm_pkg::S_RH2: begin
					if (p_val == h_q)
						tail_q <= NONE;
					state_q <= npqm_pkg::S_RH3;
				end
				npqm_pkg::S_RH3: begin
					res_q   <= h_q;
					state_q <= npqm_pkg::S_DONE;
				end
				npqm_pkg::S_PEEK: begin
					res_q   <= p_val;
					state_q <= npqm_pkg::S_DONE;
				end
				npqm_pkg::S_CMP: begin
					state_q <= (cur_q == node_q) ? npqm_pkg::S_F2 : npqm_pkg::S_WALK;
				end
				npqm_pkg::S_WALK: begin
					// stop at a broken link, back at the tail, or after NODES checks
					if (n_val >= NONE || n_val == tail_q || k_q == LAST) begin
						state_q <= npqm_pkg::S_DONE;
					end else begin
						cur_q   <= n_val;
						k_q     <= k_q + IW'(1);
						state_q <= npqm_pkg::S_CMP;
					end
				end
				npqm_pkg::S_F2: begin
					if (n_val == cur_q)
						tail_q <= NONE;
					else if (cur_q == tail_q)
						tail_q <= n_val;
					state_q <= npqm_pkg::S_F3;
				end
				npqm_pkg::S_F3: begin
					res_q   <= cur_q;
					state_q <= npqm_pkg::S_DONE;
				end
				npqm_pkg::S_DONE: begin
					// hold until the output register is free
					if (!out_v_q || m_tready) begin
						out_q   <= OUT_W'({tail_q, res_q});
						state_q <= npqm_pkg::S_IDLE;
					end
				end
				default: state_q <= npqm_pkg::S_IDLE;
			endcase
		end
	end

	`NPQ_ASSERT(a_fh_range, fh_q <= NONE, "free stack head out of range")
	`NPQ_ASSERT(a_accept_disp, (s_tvalid && s_tready) |=> (state_q == npqm_pkg::S_DISP),
		"accepted transaction did not start the sequencer")
	`NPQ_ASSERT(a_out_range, m_tvalid |-> (m_tdata[2*LW-1:LW] <= NONE),
		"new tail out of range")
	`NPQ_ASSERT(a_walk_bound, (state_q == npqm_pkg::S_CMP) |-> (cur_q < NONE),
		"ring walk on an invalid node")

endmodule

// ===== tb/tb_node_pool_queue_manager_unit.sv =====
// Testbench for node_pool_queue_manager_unit: drives pool and queue operations over the
// stream input and checks every result against a behavioural predictor of the pool.
// Depends on npqm_pkg and the RTL only.
module tb_node_pool_queue_manager_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 32;
	localparam int NONE = NODES;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;	// operation[2:0], node[8:3], tail[14:9], zero
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;	// result_node[5:0], new_tail[11:6], zero

	typedef struct packed {
		logic [5:0] node;
		logic [5:0] tail;
	} outcome_t;

	node_pool_queue_manager_unit #(.NODES(NODES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state
	int pool_top;
	int nxt[NODES];
	int prv[NODES];
	// testbench-side bookkeeping: queue tails, queue membership
	int qtail[4];
	int qmembers[4][$];
	outcome_t expected_q[$];

	int errors;
	int idle_in_pct, idle_out_pct;
	int hold_off;
	bit hold_req, hold_seen;
	int quiet_cycles;
	bit stim_done;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int clip(int v);
		return (v < NODES) ? v : NONE;
	endfunction

	function automatic int next_of(int i);
		return (i < NODES) ? nxt[i] : NONE;
	endfunction

	function automatic int prev_of(int i);
		return (i < NODES) ? prv[i] : NONE;
	endfunction

	function automatic void set_next(int i, int v);
		if (i < NODES) nxt[i] = v;
	endfunction

	function automatic void set_prev(int i, int v);
		if (i < NODES) prv[i] = v;
	endfunction

	// Apply one operation to the pool and return what the block must answer.
	function automatic outcome_t pool_apply(logic [2:0] op, int node_in, int tail_in);
		int node, tail, res, h, p, cur;
		bit found;
		outcome_t o;
		node = clip(node_in);
		tail = clip(tail_in);
		res = NONE;
		case (op)
			npqm_pkg::OP_ALLOC: if (pool_top < NODES) begin
				res = pool_top;
				pool_top = next_of(res);
				set_next(res, NONE);
				set_prev(res, NONE);
			end
			npqm_pkg::OP_FREE: if (node < NODES) begin
				nxt[node] = pool_top;
				pool_top = node;
			end
			npqm_pkg::OP_INSERT: if (node < NODES) begin
				res = node;
				if (tail >= NODES) begin
					nxt[node] = node;
					prv[node] = node;
				end else begin
					nxt[node] = tail;
					p = prv[tail];
					prv[node] = p;
					set_next(p, node);
					prv[tail] = node;
				end
				tail = node;
			end
			npqm_pkg::OP_RM_HEAD: if (tail < NODES) begin
				h = prv[tail];
				if (h < NODES) begin
					p = prv[h];
					if (p == h) tail = NONE;
					else begin
						prv[tail] = p;
						set_next(p, tail);
					end
					set_next(h, NONE);
					set_prev(h, NONE);
					res = h;
				end
			end
			npqm_pkg::OP_RM_NODE: if (tail < NODES && node < NODES) begin
				cur = tail;
				found = 0;
				for (int s = 0; s < NODES; s++) begin
					if (cur == node) begin
						found = 1;
						break;
					end
					cur = next_of(cur);
					if (cur >= NODES || cur == tail) break;
				end
				if (found) begin
					if (nxt[cur] == cur) tail = NONE;
					else begin
						if (cur == tail) tail = nxt[cur];
						set_next(prev_of(cur), nxt[cur]);
						set_prev(nxt[cur], prv[cur]);
					end
					set_next(cur, NONE);
					set_prev(cur, NONE);
					res = cur;
				end
			end
			npqm_pkg::OP_PEEK_HEAD: if (tail < NODES) res = prv[tail];
			default: ;
		endcase
		o.node = res[5:0];
		o.tail = tail[5:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Send one transaction; random gaps before it follow the sender idle rate.
	task automatic send_op(logic [2:0] op, int node, int tail);
		outcome_t o;
		// let the previous transaction drop first; the block is busy then anyway
		@(posedge clk);
		while ($urandom_range(99) < idle_in_pct) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, tail[5:0], node[5:0], op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		o = pool_apply(op, node, tail);
		expected_q.push_back(o);
		s_tvalid <= 1'b0;
	endtask

	// Keep the bookkeeping in step with what a well-formed operation does.
	task automatic op_alloc(output int n);
		n = pool_top;
		send_op(npqm_pkg::OP_ALLOC, $urandom_range(63), NONE);
	endtask

	task automatic op_free(int n);
		send_op(npqm_pkg::OP_FREE, n, $urandom_range(63));
	endtask

	task automatic op_insert(int q, int n);
		send_op(npqm_pkg::OP_INSERT, n, qtail[q]);
		qtail[q] = n;
		qmembers[q].push_back(n);
	endtask

	task automatic op_rm_head(int q);
		int h;
		h = (qmembers[q].size() > 0) ? qmembers[q][0] : NONE;
		send_op(npqm_pkg::OP_RM_HEAD, $urandom_range(63), qtail[q]);
		qtail[q] = expected_q[$].tail;
		if (h != NONE) void'(qmembers[q].pop_front());
	endtask

	task automatic op_rm_node(int q, int n);
		send_op(npqm_pkg::OP_RM_NODE, n, qtail[q]);
		qtail[q] = expected_q[$].tail;
		foreach (qmembers[q][i]) if (qmembers[q][i] == n) begin
			qmembers[q].delete(i);
			break;
		end
	endtask

	// Release all queued nodes back to the pool.
	task automatic drain_queues();
		int n;
		for (int q = 0; q < 4; q++)
			while (qmembers[q].size() > 0) begin
				n = qmembers[q][0];
				op_rm_head(q);
				op_free(n);
			end
	endtask

	task automatic wait_idle();
		while (expected_q.size() > 0) @(posedge clk);
	endtask

	task automatic test_directed();
		int a, b, c;
		op_alloc(a);
		op_alloc(b);
		op_alloc(c);
		send_op(npqm_pkg::OP_PEEK_HEAD, 0, NONE);	// peek empty queue
		send_op(npqm_pkg::OP_RM_HEAD, 0, 63);	// out of range tail counts as empty
		send_op(npqm_pkg::OP_INSERT, NONE, NONE);	// insert of none
		send_op(npqm_pkg::OP_FREE, 63, 5);	// free of none
		send_op(3'd6, 1, 2);	// undefined codes
		send_op(3'd7, 63, 63);
		op_insert(0, a);
		op_insert(0, b);
		op_insert(0, c);
		send_op(npqm_pkg::OP_PEEK_HEAD, 0, qtail[0]);
		send_op(npqm_pkg::OP_RM_NODE, NONE, qtail[0]);	// absent node
		op_rm_node(0, b);	// middle
		op_rm_node(0, c);	// tail itself
		op_rm_node(0, a);	// last node empties the ring
		op_free(a);
		op_free(b);
		op_free(c);
	endtask

	task automatic test_exhaust_pool();
		int n;
		int got[$];
		for (int i = 0; i < NODES; i++) begin
			op_alloc(n);
			got.push_back(n);
		end
		op_alloc(n);	// empty pool
		for (int i = 0; i < NODES; i++) op_insert(1, got[i]);	// full ring
		op_rm_node(1, got[NODES-1 - 3]);
		drain_queues();
	endtask

	task automatic test_random(int count);
		int q, n, k, sel;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			q = $urandom_range(3);
			if (sel < 25) begin
				op_alloc(n);
				if (n < NODES) op_insert(q, n);
			end else if (sel < 45) begin
				if (qmembers[q].size() > 0) begin
					n = qmembers[q][0];
					op_rm_head(q);
					op_free(n);
				end else op_rm_head(q);
			end else if (sel < 65) begin
				if (qmembers[q].size() > 0) begin
					k = $urandom_range(qmembers[q].size() - 1);
					n = qmembers[q][k];
					op_rm_node(q, n);
					op_free(n);
				end else op_rm_node(q, $urandom_range(63));
			end else if (sel < 80) begin
				send_op(npqm_pkg::OP_PEEK_HEAD, $urandom_range(63), qtail[q]);
			end else if (sel < 88) begin
				// node not in this queue: any node index outside it, or none
				n = (sel & 1) ? $urandom_range(32, 63) : $urandom_range(NODES - 1);
				if (qmembers[q].size() > 0 && n < NODES) begin
					k = 0;
					foreach (qmembers[q][j]) if (qmembers[q][j] == n) k = 1;
					if (!k) send_op(npqm_pkg::OP_RM_NODE, n, qtail[q]);
				end else if (qmembers[q].size() > 0)
					send_op(npqm_pkg::OP_RM_NODE, n, qtail[q]);
			end else if (sel < 94) begin
				send_op(3'($urandom_range(6, 7)), $urandom_range(63), $urandom_range(63));
			end else begin
				// noise with no link reads: free of none, insert of none, empty queue ops
				case ($urandom_range(3))
					0: send_op(npqm_pkg::OP_FREE, $urandom_range(32, 63), $urandom_range(63));
					1: send_op(npqm_pkg::OP_INSERT, $urandom_range(32, 63),
						$urandom_range(63));
					2: send_op(npqm_pkg::OP_PEEK_HEAD, $urandom_range(63),
						$urandom_range(32, 63));
					default: send_op(npqm_pkg::OP_RM_NODE, $urandom_range(63),
						$urandom_range(32, 63));
				endcase
			end
		end
	endtask

	// Stall the result side long enough for the input to back up.
	task automatic test_backpressure();
		int n;
		hold_req = !hold_req;
		for (int i = 0; i < 4; i++) op_alloc(n);
		for (int i = 0; i < 4; i++) send_op(npqm_pkg::OP_PEEK_HEAD, 0, NONE);
		wait_idle();
	endtask

	// Receiver: random stalls, plus a counted hold-off when requested.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_off <= 200;
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else m_tready <= ($urandom_range(99) >= idle_out_pct);
	end

	// Result checker.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				outcome_t w;
				w = expected_q.pop_front();
				if (m_tdata[5:0] !== w.node) report_mismatch("result_node", m_tdata[5:0], w.node);
				if (m_tdata[11:6] !== w.tail) report_mismatch("new_tail", m_tdata[11:6], w.tail);
				if (m_tdata[15:12] !== 4'd0) report_mismatch("padding", m_tdata[15:12], 0);
			end
		end
	end

	// Watchdog over cycles without any transaction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || stim_done)
			quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_node_pool_queue_manager_unit NOT OK");
			$finish;
		end
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_req = 1'b0;
		stim_done = 0;
		idle_in_pct = 30;
		idle_out_pct = 60;
		pool_top = 0;
		for (int i = 0; i < NODES; i++) begin
			nxt[i] = i + 1;
			prv[i] = 0;
		end
		for (int q = 0; q < 4; q++) qtail[q] = NONE;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_exhaust_pool();
		test_backpressure();
		test_random(150);
		idle_in_pct = 60;
		idle_out_pct = 30;
		test_random(150);
		idle_in_pct = 0;
		idle_out_pct = 0;
		test_random(150);
		drain_queues();

		guard = 0;
		while (expected_q.size() > 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		stim_done = 1;
		repeat (2 * NODES + 20) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("tb_node_pool_queue_manager_unit OK");
		else
			$display("tb_node_pool_queue_manager_unit NOT OK");
		$finish;
	end

endmodule

// ===== node_pool_queue_manager_unit.f =====
+incdir+hdl
hdl/npqm_pkg.sv
hdl/node_pool_queue_manager_unit.sv
tb/tb_node_pool_queue_manager_unit.sv
